// ----- hw/rtl/gsm7u_pkg.sv -----
// ----------------------------------------------------------------------------
// gsm7u_pkg
// Shared types, constants and the hex character decoder for the GSM 7-bit
// septet unpacker.
// ----------------------------------------------------------------------------
package gsm7u_pkg;

    // Default number of septet entries in the output queue.
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Letters 'a'..'f' and 'A'..'F' have low nibbles 1..6; adding this bias
    // gives their hex values 10..15.
    localparam logic [3:0] HEX_ALPHA_BIAS = 4'h9;

    localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
    localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
    localparam logic [7:0] CHAR_UPPER_HI = 8'h46;
    localparam logic [7:0] CHAR_LOWER_LO = 8'h61;
    localparam logic [7:0] CHAR_LOWER_HI = 8'h66;

    // Number of septets a single byte can produce.
    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    // Last position in a group of seven packed bytes.
    localparam logic [2:0] GROUP_LAST_POS = 3'd6;

    typedef logic [6:0] septet_t;

    typedef struct packed {
        septet_t septet;
        logic    last;
    } sept_entry_t;

    // Septets handed from the unpack stage to the output queue in one cycle.
    typedef struct packed {
        logic [1:0]  num;
        sept_entry_t first;
        sept_entry_t second;
    } sept_push_t;

    // Decodes one ASCII hex character; anything that is not a hex digit
    // decodes as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] value;
        value = 4'h0;
        if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI)
        begin
            value = c[3:0];
        end
        else if ((c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) ||
                 (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI))
        begin
            value = c[3:0] + HEX_ALPHA_BIAS;
        end
        return value;
    endfunction

endpackage

// ----- hw/rtl/gsm7u_char_if.sv -----
// ----------------------------------------------------------------------------
// gsm7u_char_if
// Valid/ready channel that carries one ASCII hex character per transfer.
// ----------------------------------------------------------------------------
interface gsm7u_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] hex_char;
    logic       last_char;

    modport source (output valid, output hex_char, output last_char, input ready);
    modport sink   (input valid, input hex_char, input last_char, output ready);
endinterface

// ----- hw/rtl/gsm7u_septet_if.sv -----
// ----------------------------------------------------------------------------
// gsm7u_septet_if
// Valid/ready channel that carries one unpacked septet per transfer.
// ----------------------------------------------------------------------------
interface gsm7u_septet_if;
    logic       valid;
    logic       ready;
    logic [6:0] septet;
    logic       last_septet;

    modport source (output valid, output septet, output last_septet, input ready);
    modport sink   (input valid, input septet, input last_septet, output ready);
endinterface

// ----- hw/rtl/gsm7u_unpack.sv -----
// ----------------------------------------------------------------------------
// gsm7u_unpack
// Input register, nibble pairing and septet unpacking. Produces zero, one or
// two septets per character into the output queue.
// ----------------------------------------------------------------------------
module gsm7u_unpack
    import gsm7u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gsm7u_char_if.sink chars,
    input  logic       room,
    output sept_push_t push
);

    logic       in_valid_reg;
    logic [7:0] hex_reg;
    logic       last_reg;

    logic       phase_reg,  phase_next;
    logic [3:0] held_reg,   held_next;
    logic [6:0] carry_reg,  carry_next;
    logic [2:0] pos_reg,    pos_next;

    logic        fire;
    logic        makes_byte;
    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic [2:0]  k;
    logic [14:0] byte_shl;
    logic [2:0]  shamt;
    logic [7:0]  byte_shr;
    logic [6:0]  carry_new;
    logic        group_end;
    septet_t     sep0;
    septet_t     sep1;

    always_comb
    begin
        fire        = in_valid_reg && room;
        chars.ready = !in_valid_reg || fire;

        nib        = hex_value(hex_reg);
        makes_byte = phase_reg || last_reg;
        byte_val   = phase_reg ? {held_reg, nib} : {nib, 4'h0};

        k         = (pos_reg > GROUP_LAST_POS) ? GROUP_LAST_POS : pos_reg;
        group_end = (k == GROUP_LAST_POS);

        byte_shl  = {7'b0, byte_val} << k;
        sep0      = byte_shl[6:0] | carry_reg;
        shamt     = 3'd7 - k;
        byte_shr  = byte_val >> shamt;
        carry_new = byte_shr[6:0];
        sep1      = group_end ? byte_val[7:1] : carry_new;

        // A final byte always yields two septets: either the group's second
        // septet or the leftover carry bits.
        if (!fire || !makes_byte)
        begin
            push.num = PUSH_NONE;
        end
        else if (group_end || last_reg)
        begin
            push.num = PUSH_TWO;
        end
        else
        begin
            push.num = PUSH_ONE;
        end
        push.first  = '{septet: sep0, last: 1'b0};
        push.second = '{septet: sep1, last: last_reg};

        phase_next = phase_reg;
        held_next  = held_reg;
        carry_next = carry_reg;
        pos_next   = pos_reg;
        if (fire)
        begin
            if (!makes_byte)
            begin
                held_next  = nib;
                phase_next = 1'b1;
            end
            else if (last_reg)
            begin
                phase_next = 1'b0;
                held_next  = 4'h0;
                carry_next = 7'h0;
                pos_next   = 3'd0;
            end
            else
            begin
                phase_next = 1'b0;
                carry_next = group_end ? 7'h0 : carry_new;
                pos_next   = group_end ? 3'd0 : k + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
            held_reg     <= 4'h0;
            carry_reg    <= 7'h0;
            pos_reg      <= 3'd0;
        end
        else
        begin
            if (chars.ready)
            begin
                in_valid_reg <= chars.valid;
            end
            phase_reg <= phase_next;
            held_reg  <= held_next;
            carry_reg <= carry_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            hex_reg  <= chars.hex_char;
            last_reg <= chars.last_char;
        end
    end

endmodule

// ----- hw/rtl/gsm7u_out_queue.sv -----
// ----------------------------------------------------------------------------
// gsm7u_out_queue
// Small septet queue that takes up to two entries per cycle and hands one
// per transfer to the output channel.
// ----------------------------------------------------------------------------
module gsm7u_out_queue
    import gsm7u_pkg::*;
#(
    parameter  int unsigned DEPTH = QUEUE_DEPTH_DEF,
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sept_push_t         push,
    output logic               room,
    output logic [CNT_W-1:0]   level,
    gsm7u_septet_if.source     septets
);

    localparam int unsigned PTR_W = $clog2(DEPTH);

    sept_entry_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]       count_reg,  count_next;
    logic [PTR_W-1:0]       wr_ptr1;
    logic [PTR_W-1:0]       wr_ptr2;
    logic                   pop;
    sept_entry_t            head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

    always_comb
    begin
        head                = entry_reg[rd_ptr_reg];
        septets.valid       = (count_reg != '0);
        septets.septet      = head.septet;
        septets.last_septet = head.last;
        pop                 = septets.valid && septets.ready;

        // Space for a full pair is required before the unpack stage moves.
        room  = (count_reg <= CNT_W'(DEPTH - 2));
        level = count_reg;

        wr_ptr1 = ptr_inc(wr_ptr_reg);
        wr_ptr2 = ptr_inc(wr_ptr1);

        unique case (push.num)
            PUSH_NONE: wr_ptr_next = wr_ptr_reg;
            PUSH_ONE:  wr_ptr_next = wr_ptr1;
            PUSH_TWO:  wr_ptr_next = wr_ptr2;
            default:   wr_ptr_next = wr_ptr_reg;
        endcase

        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.num) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.num == PUSH_ONE || push.num == PUSH_TWO)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == PUSH_TWO)
        begin
            entry_reg[wr_ptr1] <= push.second;
        end
    end

endmodule

// ----- hw/rtl/gsm7_septet_unpacker_hex_in.sv -----
// ----------------------------------------------------------------------------
// gsm7_septet_unpacker_hex_in
// Unpacks GSM 7-bit septets from a stream of ASCII hex characters.
// ----------------------------------------------------------------------------
// The chars channel takes one ASCII hex character per transfer, upper or
// lower case; any other code counts as a zero nibble. Two characters form a
// byte, high nibble first, and last_char marks the end of the message. A
// final character on an odd count forms a byte with a zero low nibble.
// The septets channel returns one 7-bit character per transfer, unpacked
// least significant bit first; last_septet marks the message's final septet,
// which holds any leftover bits padded with zeros.
// The first septet of a byte is offered once the character that completes
// the byte has passed the input register and been written to the output
// queue. The block takes one character every cycle while the queue has room
// for a pair. Every seventh byte and every final byte yield two septets; the
// output queue absorbs the extra one. Input pauses whenever the queue lacks
// room for a pair, which happens when the receiver stalls or when septets
// arrive faster than one per cycle, as in a run of one-character messages.
// While the receiver stalls, offered septets hold and the queue fills; input
// ready drops when the unpack stage can no longer drain.
// Reset clears the input stage, the nibble pairing, the carry bits and the
// queue; the next character starts a new message, as after every last_char.
// ----------------------------------------------------------------------------
module gsm7_septet_unpacker_hex_in
    import gsm7u_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    gsm7u_char_if.sink     chars,
    gsm7u_septet_if.source septets
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Septets produced by the unpack stage this cycle and the queue's
    // answer whether a full pair fits.
    sept_push_t       push;
    logic             room;
    logic [CNT_W-1:0] level;

    // Input register, nibble pairing and the bit-level unpacking.
    gsm7u_unpack u_unpack (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .room  (room),
        .push  (push)
    );

    // Output queue that parts the unpack stage from the receiver.
    gsm7u_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room    (room),
        .level   (level),
        .septets (septets)
    );

`ifndef SYNTHESIS
    // The unpack stage never writes when the queue lacks room for a pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != PUSH_NONE) |-> room)
        else $error("septet push without queue room");

    // A message end always yields a pair, so the first septet is never last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != PUSH_NONE) |-> !push.first.last)
        else $error("message end on a single septet");

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        level <= CNT_W'(QUEUE_DEPTH))
        else $error("septet queue overflow");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hex-fed GSM 7-bit septet unpacker.
// ----------------------------------------------------------------------------
// A queue of characters, grouped into messages that each end with last_char,
// feeds a clocked driver on the chars channel. On every accepted transfer the
// driver runs a local septet predictor and appends the septets that the
// character should release to a queue of expected septets. A clocked monitor
// compares each septet transfer with the oldest expectation, field by field.
// The run walks through three idling phases and includes a long receiver
// hold-off and one sender pause that waits for every expected septet to come.
// ----------------------------------------------------------------------------
module tb;
    import gsm7u_pkg::*;

    // Character counts at which the idling phases change. In the first phase
    // the sender idles often and the receiver most of the time; in the
    // second phase the shares swap; in the third phase nobody idles.
    localparam int PHASE1_AT     = 525;
    localparam int PHASE2_AT     = 1025;

    // The receiver holds off once for a long stretch during the third phase,
    // while the sender keeps offering characters, so the output queue fills
    // and the block has to stall its input.
    localparam int HOLD_AT       = 1150;
    localparam int HOLD_LEN      = 400;

    // The sender pauses once, after this many random characters, until every
    // expected septet has been seen.
    localparam int DRAIN_AT      = 700;

    localparam int RAND_CHARS    = 1500;

    // The longest correct stretch without any transfer is the receiver
    // hold-off above; the watchdog allows many times that.
    localparam int STUCK_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 20;

    // Hex letters decode to ten and up.
    localparam logic [7:0] ALPHA_BASE = 8'd10;

    // One character waiting to be sent. A drain entry carries no character:
    // it holds the sender back until nothing is expected any more.
    typedef struct {
        logic [7:0] code;
        logic       last;
        bit         drain;
    } char_item_t;

    logic clk;
    logic rst_n;

    gsm7u_char_if   chars_bus();
    gsm7u_septet_if septets_bus();

    gsm7_septet_unpacker_hex_in u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_bus),
        .septets (septets_bus)
    );

    always #1 clk = ~clk;

    char_item_t  char_q[$];
    sept_entry_t expected_septets[$];

    int error_count;
    int chars_taken;
    int stuck_cycles;
    int hold_left;
    bit hold_used;

    // Private copy of the unpacker state.
    logic       pair_low;      // 1 while a high nibble is held
    logic [3:0] held_nibble;
    logic [6:0] carry;
    logic [2:0] group_pos;     // bytes taken in the current group of seven

    // ------------------------------------------------------------------------
    // Septet predictor.
    // ------------------------------------------------------------------------

    // Decodes one character; any code outside the three hex ranges is zero.
    function automatic logic [3:0] nibble_of(input logic [7:0] code);
        logic [7:0] d;
        d = 8'd0;
        if (code >= CHAR_DIGIT_LO && code <= CHAR_DIGIT_HI)
        begin
            d = code - CHAR_DIGIT_LO;
        end
        else if (code >= CHAR_LOWER_LO && code <= CHAR_LOWER_HI)
        begin
            d = code - CHAR_LOWER_LO + ALPHA_BASE;
        end
        else if (code >= CHAR_UPPER_LO && code <= CHAR_UPPER_HI)
        begin
            d = code - CHAR_UPPER_LO + ALPHA_BASE;
        end
        return d[3:0];
    endfunction

    // Unpacks one byte into one or two septets, plus a closing septet that
    // holds the leftover carry when the message ends off a group boundary.
    task automatic unpack_byte(input logic [7:0] data, input logic final_byte);
        logic [14:0] shifted;
        sept_entry_t ent;
        sept_entry_t outs[3];
        int          n;
        n = 0;
        shifted = {7'd0, data} << group_pos;
        ent.septet = carry | shifted[6:0];
        ent.last = 1'b0;
        outs[n] = ent;
        n++;
        if (group_pos == GROUP_LAST_POS)
        begin
            // The seventh byte of a group completes a second septet.
            ent.septet = data[7:1];
            outs[n] = ent;
            n++;
            carry = 7'd0;
            group_pos = 3'd0;
        end
        else
        begin
            shifted = {7'd0, data} >> (3'd7 - group_pos);
            carry = shifted[6:0];
            group_pos = group_pos + 3'd1;
        end
        if (final_byte)
        begin
            if (group_pos != 3'd0)
            begin
                ent.septet = carry;
                ent.last = 1'b1;
                outs[n] = ent;
                n++;
            end
            else
            begin
                // A message that ends on a group boundary has no carry, so
                // its last flag rides on the second septet of that byte.
                outs[n - 1].last = 1'b1;
            end
            pair_low = 1'b0;
            held_nibble = 4'd0;
            carry = 7'd0;
            group_pos = 3'd0;
        end
        for (int i = 0; i < n; i++)
        begin
            expected_septets.push_back(outs[i]);
        end
    endtask

    // Advances the predictor by one accepted character.
    task automatic predict_septets(input logic [7:0] code, input logic last);
        logic [3:0] nib;
        nib = nibble_of(code);
        if (!pair_low)
        begin
            if (last)
            begin
                // An odd final character gets a zero low nibble.
                unpack_byte({nib, 4'd0}, 1'b1);
            end
            else
            begin
                held_nibble = nib;
                pair_low = 1'b1;
            end
        end
        else
        begin
            pair_low = 1'b0;
            unpack_byte({held_nibble, nib}, last);
        end
    endtask

    // ------------------------------------------------------------------------
    // Idling shares per phase, in percent of cycles.
    // ------------------------------------------------------------------------

    function automatic int sender_idle_pct();
        if (chars_taken < PHASE1_AT)
        begin
            return 24;
        end
        else if (chars_taken < PHASE2_AT)
        begin
            return 56;
        end
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (chars_taken < PHASE1_AT)
        begin
            return 56;
        end
        else if (chars_taken < PHASE2_AT)
        begin
            return 24;
        end
        return 0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (char %0d)",
                 what, got, want, chars_taken);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------------

    task automatic add_char(input logic [7:0] code, input logic last);
        char_item_t item;
        item.code = code;
        item.last = last;
        item.drain = 1'b0;
        char_q.push_back(item);
    endtask

    // Queues a whole message; its final character carries last_char.
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_char(s[i], i == s.len() - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Character driver. A transfer happens at an edge where valid and ready
    // are both high; at that edge the predictor runs on the character that
    // was on the bus. Valid gets one assignment per edge at most, so a held
    // offer is never dropped and raised again within the same step.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : char_driver
        bit offering;
        if (rst_n)
        begin
            offering = chars_bus.valid;
            if (chars_bus.valid && chars_bus.ready)
            begin
                predict_septets(char_q[0].code, char_q[0].last);
                void'(char_q.pop_front());
                chars_taken++;
                offering = 1'b0;
            end
            if (!offering && char_q.size() != 0)
            begin
                if (char_q[0].drain)
                begin
                    // Pause until every expected septet has come back.
                    if (expected_septets.size() == 0)
                    begin
                        void'(char_q.pop_front());
                    end
                    chars_bus.valid <= 1'b0;
                end
                else if ($urandom_range(99) >= sender_idle_pct())
                begin
                    chars_bus.valid     <= 1'b1;
                    chars_bus.hex_char  <= char_q[0].code;
                    chars_bus.last_char <= char_q[0].last;
                end
                else
                begin
                    chars_bus.valid <= 1'b0;
                end
            end
            else if (!offering)
            begin
                chars_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver ready. Random stalls follow the current phase; once, in the
    // third phase, the receiver holds ready low without a break for HOLD_LEN.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                septets_bus.ready <= 1'b0;
            end
            else if (!hold_used && chars_taken >= HOLD_AT)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_LEN - 1;
                septets_bus.ready <= 1'b0;
            end
            else
            begin
                septets_bus.ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Septet monitor. Each transfer is checked against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : septet_monitor
        sept_entry_t want;
        if (rst_n && septets_bus.valid && septets_bus.ready)
        begin
            if (expected_septets.size() == 0)
            begin
                report_mismatch("unexpected septet", int'(septets_bus.septet), 0);
            end
            else
            begin
                want = expected_septets.pop_front();
                if (septets_bus.septet !== want.septet)
                begin
                    report_mismatch("septet", int'(septets_bus.septet),
                                    int'(want.septet));
                end
                if (septets_bus.last_septet !== want.last)
                begin
                    report_mismatch("last_septet", int'(septets_bus.last_septet),
                                    int'(want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when neither channel has a transfer for an
    // unbroken stretch that reaches STUCK_LIMIT.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((chars_bus.valid && chars_bus.ready) ||
                (septets_bus.valid && septets_bus.ready))
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, stimulus, drain and verdict.
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        string      hex_set;
        char_item_t pause_item;
        int         sent;
        int         len;
        bit         drain_placed;
        logic [7:0] code;

        hex_set = "0123456789abcdefABCDEF";
        clk = 1'b0;
        rst_n = 1'b0;
        chars_bus.valid = 1'b0;
        chars_bus.hex_char = 8'd0;
        chars_bus.last_char = 1'b0;
        septets_bus.ready = 1'b0;
        error_count = 0;
        chars_taken = 0;
        stuck_cycles = 0;
        hold_left = 0;
        hold_used = 1'b0;
        pair_low = 1'b0;
        held_nibble = 4'd0;
        carry = 7'd0;
        group_pos = 3'd0;

        // Directed messages. A lone final character exercises the odd count
        // with a zero low nibble; a two-character message ends with carry
        // bits; fourteen characters end exactly on a group boundary with
        // mixed-case digits; the last message is made of codes just outside
        // the hex ranges and the two byte extremes, all decoding as zero.
        add_text("F");
        add_text("00");
        add_text("FFffAa09Bb8cDe");
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b0);
        add_text("/:@G`g");

        // Random messages, mostly short, some spanning several groups. Most
        // characters are hex digits; the rest are arbitrary byte codes.
        sent = 0;
        drain_placed = 1'b0;
        while (sent < RAND_CHARS)
        begin
            if ($urandom_range(9) == 0)
            begin
                len = $urandom_range(60, 30);
            end
            else
            begin
                len = $urandom_range(20, 1);
            end
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(4) == 0)
                begin
                    code = 8'($urandom_range(255));
                end
                else
                begin
                    code = hex_set[$urandom_range(hex_set.len() - 1)];
                end
                add_char(code, i == len - 1);
            end
            sent += len;
            if (!drain_placed && sent >= DRAIN_AT)
            begin
                pause_item.code = 8'd0;
                pause_item.last = 1'b0;
                pause_item.drain = 1'b1;
                char_q.push_back(pause_item);
                drain_placed = 1'b1;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (char_q.size() != 0 || expected_septets.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
